// ===== rtl/eic_pkg.sv =====
package eic_pkg;

  localparam int LINES = 16;
  localparam int PORTS = 4;
  localparam int DATA_W = 16;
  localparam int PIN_W = 64;
  localparam int SEL_W = 4;
  localparam int IRQ_W = 7;
  localparam int MAX_LINES = 16;

  localparam logic [DATA_W-1:0] LINE_MASK = DATA_W'((32'd1 << LINES) - 32'd1);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    REG_IMR  = 4'd0,
    REG_EMR  = 4'd1,
    REG_RISE = 4'd2,
    REG_FALL = 4'd3,
    REG_PEND = 4'd4,
    REG_SEL0 = 4'd5,
    REG_SEL1 = 4'd6,
    REG_SEL2 = 4'd7,
    REG_SEL3 = 4'd8
  } reg_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [3:0]        reg_index;
    logic [DATA_W-1:0] write_data;
    logic [PIN_W-1:0]  pin_levels;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] pending_lines;
    logic [IRQ_W-1:0]  irq_requests;
    logic [DATA_W-1:0] event_pulses;
  } out_word_t;

  typedef struct packed {
    logic             tick;
    logic             sel_we;
    logic [SEL_W-1:0] sel_wdata;
    logic             rise_en;
    logic             fall_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic [SEL_W-1:0] sel;
  } lane_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0] imr;
    logic [DATA_W-1:0] emr;
    logic [DATA_W-1:0] rise;
    logic [DATA_W-1:0] fall;
    logic [DATA_W-1:0] pend;
  } regs_t;

  function automatic logic [IRQ_W-1:0] irq_of(input logic [DATA_W-1:0] p);
    logic [IRQ_W-1:0] r;
    r = {|p[15:10], |p[9:5], p[4:0]};
    return r;
  endfunction

endpackage

// ===== rtl/eic_lane.sv =====
module eic_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  eic_pkg::lane_ctrl_t           ctrl_i,
  input  logic [eic_pkg::PORTS-1:0]     pins_i,
  output eic_pkg::lane_stat_t           stat_o
);
  import eic_pkg::*;

  logic [SEL_W-1:0] sel_q, sel_d;
  logic             prev_q, prev_d;
  logic             cur;

  always_comb begin
    cur = 1'b0;
    for (int p = 0; p < PORTS; p++) begin
      if (sel_q == SEL_W'(p)) begin
        cur = pins_i[p];
      end
    end
  end

  assign sel_d  = ctrl_i.sel_we ? ctrl_i.sel_wdata : sel_q;
  assign prev_d = ctrl_i.tick ? cur : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= '0;
      prev_q <= 1'b0;
    end else begin
      sel_q  <= sel_d;
      prev_q <= prev_d;
    end
  end

  assign stat_o.hit = (cur & ~prev_q & ctrl_i.rise_en) | (~cur & prev_q & ctrl_i.fall_en);
  assign stat_o.sel = sel_q;

endmodule

// ===== rtl/eic_merge.sv =====
module eic_merge (
  input  eic_pkg::in_word_t                                   word_i,
  input  eic_pkg::regs_t                                      regs_i,
  input  logic [eic_pkg::DATA_W-1:0]                          hits_i,
  input  logic [eic_pkg::MAX_LINES-1:0][eic_pkg::SEL_W-1:0]   sels_i,
  output logic [eic_pkg::DATA_W-1:0]                          pend_next_o,
  output eic_pkg::out_word_t                                  word_o
);
  import eic_pkg::*;

  logic [DATA_W-1:0] rd;
  logic [DATA_W-1:0] ev;
  logic [1:0]        grp;

  assign grp = 2'(word_i.reg_index - REG_SEL0);

  always_comb begin
    pend_next_o = regs_i.pend;
    ev          = '0;
    rd          = '0;
    unique case (word_i.mode)
      MODE_TICK: begin
        pend_next_o = (regs_i.pend | (hits_i & regs_i.imr)) & LINE_MASK;
        ev          = hits_i & regs_i.emr & LINE_MASK;
      end
      MODE_WRITE: begin
        if (word_i.reg_index == REG_PEND) begin
          pend_next_o = regs_i.pend & ~word_i.write_data & LINE_MASK;
        end
      end
      MODE_READ: begin
        unique case (word_i.reg_index)
          REG_IMR:  rd = regs_i.imr;
          REG_EMR:  rd = regs_i.emr;
          REG_RISE: rd = regs_i.rise;
          REG_FALL: rd = regs_i.fall;
          REG_PEND: rd = regs_i.pend;
          REG_SEL0, REG_SEL1, REG_SEL2, REG_SEL3: begin
            for (int k = 0; k < 4; k++) begin
              rd[4*k +: 4] = sels_i[{grp, 2'(k)}];
            end
          end
          default: rd = '0;
        endcase
      end
      default: begin
        pend_next_o = regs_i.pend;
      end
    endcase
  end

  assign word_o.read_data     = rd;
  assign word_o.pending_lines = pend_next_o;
  assign word_o.irq_requests  = irq_of(pend_next_o);
  assign word_o.event_pulses  = ev;

endmodule

// ===== rtl/external_interrupt_controller_unit.sv =====
// Channel | Direction | Handshake             | Word
// input   | in        | in_valid_i/in_stall_o  | in_word_i (mode, index, data, pins)
// output  | out       | out_valid_o/out_stall_i| out_word_o (read, pending, irq, events)
//
// An accepted word's result is in the output register in the cycle after; a new word is
// accepted every cycle unless a full output stalls; lanes and merge stage are one level.
// Reset clears the control registers, the output valid, the selectors and previous levels.
// A stalled output holds its word and stalls the input only while the register is full.
module external_interrupt_controller_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  eic_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output eic_pkg::out_word_t out_word_o
);
  import eic_pkg::*;

  logic              accept;
  logic              tick;
  logic              wr;
  logic [DATA_W-1:0] wd;

  logic [DATA_W-1:0] imr_q, imr_d;
  logic [DATA_W-1:0] emr_q, emr_d;
  logic [DATA_W-1:0] rise_q, rise_d;
  logic [DATA_W-1:0] fall_q, fall_d;
  logic [DATA_W-1:0] pend_q, pend_d;
  logic [DATA_W-1:0] pend_next;

  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;
  out_word_t merged;
  regs_t     regs;

  lane_ctrl_t [MAX_LINES-1:0]              ctrl;
  lane_stat_t [MAX_LINES-1:0]              stat;
  logic [DATA_W-1:0]                       hits;
  logic [MAX_LINES-1:0][SEL_W-1:0]         sels;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign tick       = accept & (in_word_i.mode == MODE_TICK);
  assign wr         = accept & (in_word_i.mode == MODE_WRITE);
  assign wd         = in_word_i.write_data & LINE_MASK;

  for (genvar i = 0; i < MAX_LINES; i++) begin : g_line
    if (i < LINES) begin : g_lane
      logic [PORTS-1:0] pins;
      for (genvar p = 0; p < PORTS; p++) begin : g_pin
        assign pins[p] = in_word_i.pin_levels[16*p + i];
      end
      assign ctrl[i].tick      = tick;
      assign ctrl[i].sel_we    = wr & (in_word_i.reg_index == 4'(REG_SEL0) + 4'(i / 4));
      assign ctrl[i].sel_wdata = in_word_i.write_data[4*(i % 4) +: 4];
      assign ctrl[i].rise_en   = rise_q[i];
      assign ctrl[i].fall_en   = fall_q[i];

      eic_lane u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl[i]),
        .pins_i (pins),
        .stat_o (stat[i])
      );
    end else begin : g_none
      assign ctrl[i] = '0;
      assign stat[i] = '0;
    end
    assign hits[i] = stat[i].hit & ctrl[i].tick;
    assign sels[i] = stat[i].sel;
  end

  assign regs.imr  = imr_q;
  assign regs.emr  = emr_q;
  assign regs.rise = rise_q;
  assign regs.fall = fall_q;
  assign regs.pend = pend_q;

  eic_merge u_merge (
    .word_i      (in_word_i),
    .regs_i      (regs),
    .hits_i      (hits),
    .sels_i      (sels),
    .pend_next_o (pend_next),
    .word_o      (merged)
  );

  assign imr_d  = (wr && in_word_i.reg_index == REG_IMR) ? wd : imr_q;
  assign emr_d  = (wr && in_word_i.reg_index == REG_EMR) ? wd : emr_q;
  assign rise_d = (wr && in_word_i.reg_index == REG_RISE) ? wd : rise_q;
  assign fall_d = (wr && in_word_i.reg_index == REG_FALL) ? wd : fall_q;
  assign pend_d = accept ? pend_next : pend_q;

  assign out_valid_d = accept | (out_valid_q & out_stall_i);
  assign out_word_d  = accept ? merged : out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imr_q       <= '0;
      emr_q       <= '0;
      rise_q      <= '0;
      fall_q      <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      imr_q       <= imr_d;
      emr_q       <= emr_d;
      rise_q      <= rise_d;
      fall_q      <= fall_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/eic_checker.sv =====
module eic_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input eic_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input eic_pkg::out_word_t out_word_o
);
  import eic_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted word gave no result");

  a_irq_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.irq_requests == irq_of(out_word_o.pending_lines))
    else $error("interrupt requests disagree with pending lines");

  a_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.mode != MODE_TICK |=> out_word_o.event_pulses == '0)
    else $error("event pulse on a bus word");

  a_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.mode != MODE_READ |=> out_word_o.read_data == '0)
    else $error("read data on a word that is not a read");

endmodule

bind external_interrupt_controller_unit eic_checker u_eic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

// ===== test/testbench.sv =====
module testbench;
  import eic_pkg::*;

  localparam logic [3:0] REG_UNUSED_LO = 4'd9;
  localparam logic [3:0] REG_UNUSED_HI = 4'd15;
  localparam int RANDOM_WORDS = 850;
  localparam int QUIET_FROM = 700;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 40;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  logic [DATA_W-1:0] imr_m, emr_m, rise_m, fall_m, pend_m, prev_m;
  logic [SEL_W-1:0]  sel_m [MAX_LINES];

  out_word_t         awaited_words [$];
  stim_row_t         stim_table [$];
  int                mismatches = 0;
  logic              quiet = 1'b0;
  logic              hold_req = 1'b0;
  bit                hold_done = 1'b0;
  int                hold_left = 0;
  int                burst_left = 0;
  bit                burst_stall = 1'b0;
  logic [PIN_W-1:0]  last_pins = '0;

  external_interrupt_controller_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #1 clk = ~clk;

  function automatic out_word_t advance_controller(input in_word_t w);
    out_word_t         o;
    logic [DATA_W-1:0] now_lv;
    logic [DATA_W-1:0] edges;
    int                line;
    int                port;
    int                k;
    o = '0;
    case (w.mode)
      MODE_TICK: begin
        now_lv = '0;
        for (line = 0; line < LINES; line++) begin
          port = int'(sel_m[line]);
          if (port < PORTS) now_lv[line] = w.pin_levels[port * MAX_LINES + line];
        end
        now_lv &= LINE_MASK;
        edges = ((now_lv & ~prev_m & rise_m) | (~now_lv & prev_m & fall_m)) & LINE_MASK;
        pend_m = (pend_m | (edges & imr_m)) & LINE_MASK;
        o.event_pulses = edges & emr_m;
        prev_m = now_lv;
      end
      MODE_WRITE: begin
        case (w.reg_index)
          REG_IMR:  imr_m = w.write_data & LINE_MASK;
          REG_EMR:  emr_m = w.write_data & LINE_MASK;
          REG_RISE: rise_m = w.write_data & LINE_MASK;
          REG_FALL: fall_m = w.write_data & LINE_MASK;
          REG_PEND: pend_m = pend_m & ~w.write_data & LINE_MASK;
          REG_SEL0, REG_SEL1, REG_SEL2, REG_SEL3: begin
            for (k = 0; k < 4; k++) begin
              line = (int'(w.reg_index) - int'(REG_SEL0)) * 4 + k;
              if (line < LINES) sel_m[line] = w.write_data[4*k +: 4];
            end
          end
          default: ;
        endcase
      end
      MODE_READ: begin
        case (w.reg_index)
          REG_IMR:  o.read_data = imr_m;
          REG_EMR:  o.read_data = emr_m;
          REG_RISE: o.read_data = rise_m;
          REG_FALL: o.read_data = fall_m;
          REG_PEND: o.read_data = pend_m;
          REG_SEL0, REG_SEL1, REG_SEL2, REG_SEL3: begin
            for (k = 0; k < 4; k++) begin
              line = (int'(w.reg_index) - int'(REG_SEL0)) * 4 + k;
              if (line < LINES) o.read_data[4*k +: 4] = sel_m[line];
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    o.pending_lines = pend_m;
    o.irq_requests[4:0] = pend_m[4:0];
    o.irq_requests[5] = (pend_m[9:5] != '0);
    o.irq_requests[6] = (pend_m[15:10] != '0);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("mismatch in %s: got %0h, expected %0h, at %0t", what, got, want, $time);
    end
  endtask

  task automatic check_output(input out_word_t got);
    out_word_t want;
    if (awaited_words.size() == 0) begin
      report_mismatch("unexpected word", 64'(got), '0);
    end else begin
      want = awaited_words.pop_front();
      if (got.read_data !== want.read_data)
        report_mismatch("read_data", 64'(got.read_data), 64'(want.read_data));
      if (got.pending_lines !== want.pending_lines)
        report_mismatch("pending_lines", 64'(got.pending_lines), 64'(want.pending_lines));
      if (got.irq_requests !== want.irq_requests)
        report_mismatch("irq_requests", 64'(got.irq_requests), 64'(want.irq_requests));
      if (got.event_pulses !== want.event_pulses)
        report_mismatch("event_pulses", 64'(got.event_pulses), 64'(want.event_pulses));
    end
  endtask

  task automatic add_row(input mode_e m, input logic [3:0] idx, input logic [15:0] data,
                         input logic [63:0] pins);
    stim_row_t r;
    r.word = '{mode: m, reg_index: idx, write_data: data, pin_levels: pins};
    r.typed = 1'b0;
    r.want = '0;
    stim_table.push_back(r);
  endtask

  task automatic add_known(input mode_e m, input logic [3:0] idx, input logic [15:0] data,
                           input logic [63:0] pins, input logic [15:0] rd,
                           input logic [15:0] pend, input logic [6:0] irq,
                           input logic [15:0] ev);
    stim_row_t r;
    r.word = '{mode: m, reg_index: idx, write_data: data, pin_levels: pins};
    r.typed = 1'b1;
    r.want = '{read_data: rd, pending_lines: pend, irq_requests: irq, event_pulses: ev};
    stim_table.push_back(r);
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t guess;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    guess = advance_controller(w);
    awaited_words.push_back(typed ? want : guess);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    int       k;
    w.mode = MODE_TICK;
    w.reg_index = 4'($urandom_range(0, 15));
    w.write_data = 16'($urandom);
    w.pin_levels = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 9) < 7) begin
        w.pin_levels = last_pins ^ (64'd1 << $urandom_range(0, 63))
                                 ^ (64'd1 << $urandom_range(0, 63));
      end else if ($urandom_range(0, 9) == 0) begin
        w.pin_levels = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end
      last_pins = w.pin_levels;
    end else if (pick < 80) begin
      w.mode = MODE_WRITE;
      if ($urandom_range(0, 9) != 0) w.reg_index = 4'($urandom_range(0, 8));
      if (w.reg_index >= REG_SEL0 && w.reg_index <= REG_SEL3) begin
        for (k = 0; k < 4; k++) begin
          w.write_data[4*k +: 4] = ($urandom_range(0, 4) != 0) ?
              4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        end
      end else if (w.reg_index != REG_PEND && $urandom_range(0, 3) == 0) begin
        w.write_data = 16'hFFFF ^ (16'd1 << $urandom_range(0, 15));
      end
    end else if (pick < 94) begin
      w.mode = MODE_READ;
    end else begin
      w.mode = MODE_NOP;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_output(out_word);
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      if (burst_left == 0) begin
        burst_stall = ($urandom_range(0, 2) == 0);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      out_stall <= burst_stall;
    end
  end

  initial begin
    #400000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    imr_m = '0;
    emr_m = '0;
    rise_m = '0;
    fall_m = '0;
    pend_m = '0;
    prev_m = '0;
    foreach (sel_m[i]) sel_m[i] = '0;

    add_known(MODE_READ, REG_IMR, 16'h0000, '0, 16'h0, 16'h0, 7'h00, 16'h0);
    add_known(MODE_READ, REG_UNUSED_LO, 16'hFFFF, '1, 16'h0, 16'h0, 7'h00, 16'h0);
    add_known(MODE_READ, REG_UNUSED_HI, 16'hFFFF, '1, 16'h0, 16'h0, 7'h00, 16'h0);
    add_known(MODE_WRITE, REG_UNUSED_LO, 16'hFFFF, '0, 16'h0, 16'h0, 7'h00, 16'h0);
    add_known(MODE_TICK, REG_IMR, 16'h0000, '1, 16'h0, 16'h0, 7'h00, 16'h0);
    add_known(MODE_TICK, REG_IMR, 16'h0000, '0, 16'h0, 16'h0, 7'h00, 16'h0);
    add_known(MODE_WRITE, REG_IMR, 16'hFFFF, '0, 16'h0, 16'h0, 7'h00, 16'h0);
    add_known(MODE_WRITE, REG_EMR, 16'hFFFF, '0, 16'h0, 16'h0, 7'h00, 16'h0);
    add_known(MODE_WRITE, REG_RISE, 16'hFFFF, '0, 16'h0, 16'h0, 7'h00, 16'h0);
    add_known(MODE_WRITE, REG_FALL, 16'hFFFF, '0, 16'h0, 16'h0, 7'h00, 16'h0);
    add_known(MODE_READ, REG_FALL, 16'h0000, '0, 16'hFFFF, 16'h0, 7'h00, 16'h0);
    add_known(MODE_TICK, REG_IMR, 16'h0000, '1, 16'h0, 16'hFFFF, 7'h7F, 16'hFFFF);
    add_known(MODE_READ, REG_PEND, 16'h0000, '0, 16'hFFFF, 16'hFFFF, 7'h7F, 16'h0);
    add_known(MODE_WRITE, REG_PEND, 16'hFFFF, '1, 16'h0, 16'h0, 7'h00, 16'h0);
    add_known(MODE_TICK, REG_IMR, 16'h0000, '0, 16'h0, 16'hFFFF, 7'h7F, 16'hFFFF);
    add_known(MODE_NOP, REG_SEL3, 16'hFFFF, 64'h0123_4567_89AB_CDEF,
              16'h0, 16'hFFFF, 7'h7F, 16'h0);
    add_known(MODE_WRITE, REG_PEND, 16'hFC00, '0, 16'h0, 16'h03FF, 7'h3F, 16'h0);
    add_known(MODE_WRITE, REG_PEND, 16'h03E0, '0, 16'h0, 16'h001F, 7'h1F, 16'h0);
    add_known(MODE_WRITE, REG_SEL0, 16'hFEDC, '0, 16'h0, 16'h001F, 7'h1F, 16'h0);
    add_known(MODE_READ, REG_SEL0, 16'h0000, '0, 16'hFEDC, 16'h001F, 7'h1F, 16'h0);
    add_row(MODE_WRITE, REG_SEL1, 16'h3210, '0);
    add_row(MODE_WRITE, REG_SEL2, 16'h4321, '0);
    add_row(MODE_WRITE, REG_SEL3, 16'h0123, '0);
    add_row(MODE_TICK, REG_IMR, 16'h0000, 64'hFFFF_0000_FFFF_0000);
    add_row(MODE_TICK, REG_IMR, 16'h0000, 64'h0000_FFFF_0000_FFFF);
    add_row(MODE_WRITE, REG_EMR, 16'h5A5A, '0);
    add_row(MODE_TICK, REG_IMR, 16'h0000, 64'hA5A5_C3C3_5A5A_3C3C);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) send_word(stim_table[i].word, stim_table[i].typed,
                                      stim_table[i].want);
    last_pins = 64'hA5A5_C3C3_5A5A_3C3C;

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == HOLD_AT) hold_req <= 1'b1;
      if (n == QUIET_FROM) quiet <= 1'b1;
      send_word(random_word(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (awaited_words.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
